// ===== hdl/perceptron_sigmoid_delta_rule_core_macros.svh =====
// Assertion macros shared by the perceptron core RTL.
`ifndef PERCEPTRON_SIGMOID_DELTA_RULE_CORE_MACROS_SVH
`define PERCEPTRON_SIGMOID_DELTA_RULE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked by clk, disabled in reset
`define PSDR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PSDR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PSDR_ASSERT_IMP(lbl, ante, cons, msg)
`define PSDR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/psdr_pkg.sv =====
// Shared types, constants and the sigmoid table function of the perceptron core.
package psdr_pkg;

  localparam int NUM_INPUTS_DEF      = 8;
  localparam int SIGMOID_ENTRIES_DEF = 256;

  localparam int OP_W    = 2;
  localparam int INDEX_W = 4;
  localparam int DATA_W  = 16;
  localparam int LEVEL_W = 16;
  localparam int FRAC_W  = 12;

  localparam int CFG_DW      = 32;
  localparam int CFG_AW      = 3;
  localparam int REG_SEL_BIT = 2;

  // err = expected - level, then learn_rate * err, then times the input
  localparam int ERR_W  = 18;
  localparam int RE_W   = 35;
  localparam int PROD_W = RE_W + DATA_W;

  localparam logic [DATA_W-1:0]        LEARN_RATE_RST = 16'd32768;
  localparam logic signed [DATA_W-1:0] BIAS_VALUE_RST = 16'sd4096;
  // 1.0 in Q4.12: bias weight input during execute
  localparam logic signed [DATA_W-1:0] X_ONE          = 16'sd4096;

  typedef enum logic [OP_W-1:0] {
    OP_WR_INPUT  = 2'd0,
    OP_WR_WEIGHT = 2'd1,
    OP_EXECUTE   = 2'd2,
    OP_TRAIN     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_LOOKUP,
    ST_DONE
  } state_t;

  typedef enum logic {
    REG_LEARN_RATE = 1'b0,
    REG_BIAS_VALUE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0]        learn_rate;
    logic signed [DATA_W-1:0] bias_value;
  } cfg_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic train;
  } mac_ctrl_t;

  typedef struct packed {
    logic                     en;
    logic signed [DATA_W-1:0] data;
  } wb_t;

  // Truncating unsigned divide by restoring shift/subtract. Elaboration only.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned dvs);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= dvs) begin
        r    = r - dvs;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid at a Q4.12 centre, Q1.15 result. Elaboration only.
  // exp(-a) is built as exp(-a/256) by a five-term series, squared eight times.
  function automatic logic [LEVEL_W-1:0] sigmoid_entry(input longint centre);
    longint unsigned a;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned t3;
    longint unsigned t4;
    longint unsigned e;
    longint unsigned den;
    longint unsigned s;
    a  = (centre < 0) ? -centre : centre;
    t  = a * 64'd1024;
    t2 = (t * t) >> 30;
    t3 = (t2 * t) >> 30;
    t4 = (t3 * t) >> 30;
    e  = (64'd1 << 30) - t + (t2 >> 1) - udiv64(t3, 64'd6) + udiv64(t4, 64'd24);
    for (int k = 0; k < 8; k++) begin
      e = (e * e) >> 30;
    end
    den = (64'd1 << 30) + e;
    s   = udiv64((64'd1 << 45) + (den >> 1), den);
    return (centre < 0) ? 16'(64'd32768 - s) : 16'(s);
  endfunction

endpackage

// ===== hdl/psdr_regs.sv =====
// APB register file holding learning rate and bias input.
module psdr_regs import psdr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t sel;

  assign sel    = reg_idx_t'(paddr[REG_SEL_BIT]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      unique case (sel)
        REG_LEARN_RATE: cfg_nxt.learn_rate = pwdata[DATA_W-1:0];
        REG_BIAS_VALUE: cfg_nxt.bias_value = $signed(pwdata[DATA_W-1:0]);
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_LEARN_RATE: prdata = {{(CFG_DW-DATA_W){1'b0}}, cfg_r.learn_rate};
      REG_BIAS_VALUE: prdata = {{(CFG_DW-DATA_W){cfg_r.bias_value[DATA_W-1]}},
                                cfg_r.bias_value};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.learn_rate <= LEARN_RATE_RST;
      cfg_r.bias_value <= BIAS_VALUE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== hdl/psdr_mem.sv =====
// Single-port-write, single-port-read RAM; entries never written read as zero.
module psdr_mem import psdr_pkg::*; #(
  parameter int DEPTH = NUM_INPUTS_DEF,
  parameter int WIDTH = DATA_W,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rvld_r <= vld_r[raddr];
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

// ===== hdl/psdr_mac.sv =====
// Shared multiplier datapath: dot-product accumulate and delta-rule weight update.
module psdr_mac import psdr_pkg::*; #(
  parameter int NUM_INPUTS = NUM_INPUTS_DEF,
  localparam int WA_W      = $clog2(NUM_INPUTS + 1),
  localparam int ACC_W     = 32 + $clog2(NUM_INPUTS + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctrl_t                ctrl,
  input  logic [WA_W-1:0]          k,
  input  logic                     re_load,
  input  logic [DATA_W-1:0]        learn_rate,
  input  logic [DATA_W-1:0]        expected,
  input  logic [LEVEL_W-1:0]       level,
  input  logic signed [DATA_W-1:0] x0,
  input  logic signed [DATA_W-1:0] w_rd,
  input  logic signed [DATA_W-1:0] x_rd,
  output logic signed [ACC_W-1:0]  acc,
  output wb_t                      wb,
  output logic [WA_W-1:0]          wb_addr
);

  localparam int DELTA_W = PROD_W - 31;
  localparam int SUM_W   = DELTA_W + 1;
  localparam logic signed [PROD_W-1:0] RND_HALF = {{(PROD_W-31){1'b0}}, 1'b1, 30'd0};

  logic signed [ERR_W-1:0]   err;
  logic signed [RE_W-1:0]    re_r;

  logic                      s1_vld_r;
  logic                      s1_first_r;
  logic [WA_W-1:0]           s1_k_r;
  logic signed [DATA_W-1:0]  x_op;
  logic signed [RE_W-1:0]    a_op;
  logic signed [PROD_W-1:0]  prod;

  logic                      s2_vld_r;
  logic                      s2_first_r;
  logic [WA_W-1:0]           s2_k_r;
  logic signed [DATA_W-1:0]  s2_w_r;
  logic signed [PROD_W-1:0]  prod_r;

  logic signed [PROD_W-1:0]  rnd;
  logic signed [DELTA_W-1:0] delta;
  logic signed [SUM_W-1:0]   wsum;
  logic                      pos_ovf;
  logic                      neg_ovf;
  logic signed [DATA_W-1:0]  w_new;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_base;

  // rate * error is fixed for the whole train walk
  assign err = $signed({2'b00, expected}) - $signed({2'b00, level});

  always_ff @(posedge clk) begin
    if (re_load) begin
      re_r <= $signed({1'b0, learn_rate}) * err;
    end
  end

  // stage 1: memory data arrives, one product per cycle
  assign x_op = s1_first_r ? x0 : x_rd;
  assign a_op = ctrl.train ? re_r : $signed({{(RE_W-DATA_W){w_rd[DATA_W-1]}}, w_rd});
  assign prod = a_op * x_op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= ctrl.vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= ctrl.first;
    s1_k_r     <= k;
    s2_first_r <= s1_first_r;
    s2_k_r     <= s1_k_r;
    s2_w_r     <= w_rd;
    prod_r     <= prod;
  end

  // stage 2: round half up at bit 31, add to weight, saturate
  assign rnd   = prod_r + RND_HALF;
  assign delta = rnd[PROD_W-1:31];
  assign wsum  = $signed({{(SUM_W-DATA_W){s2_w_r[DATA_W-1]}}, s2_w_r})
               + $signed({delta[DELTA_W-1], delta});

  assign pos_ovf = !wsum[SUM_W-1] && (|wsum[SUM_W-2:DATA_W-1]);
  assign neg_ovf = wsum[SUM_W-1] && !(&wsum[SUM_W-2:DATA_W-1]);

  always_comb begin
    priority if (pos_ovf) begin
      w_new = 16'sh7fff;
    end else if (neg_ovf) begin
      w_new = 16'sh8000;
    end else begin
      w_new = wsum[DATA_W-1:0];
    end
  end

  assign acc_base = s2_first_r ? '0 : acc_r;

  always_ff @(posedge clk) begin
    if (s2_vld_r && !ctrl.train) begin
      acc_r <= acc_base + prod_r[ACC_W-1:0];
    end
  end

  assign acc     = acc_r;
  assign wb.en   = s2_vld_r && ctrl.train;
  assign wb.data = w_new;
  assign wb_addr = s2_k_r;

endmodule

// ===== hdl/psdr_sigmoid.sv =====
// Net saturation, table index scaling and registered sigmoid table lookup.
module psdr_sigmoid import psdr_pkg::*; #(
  parameter int ACC_W           = 32 + $clog2(NUM_INPUTS_DEF + 1),
  parameter int SIGMOID_ENTRIES = SIGMOID_ENTRIES_DEF,
  localparam int IDX_W          = $clog2(SIGMOID_ENTRIES)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] acc,
  output logic                    done,
  output logic [LEVEL_W-1:0]      level
);

  localparam int NF_W = ACC_W - FRAC_W;

  logic signed [NF_W-1:0]   net_full;
  logic                     pos_ovf;
  logic                     neg_ovf;
  logic signed [DATA_W-1:0] net_sat;
  logic signed [DATA_W-1:0] net_r;
  logic [DATA_W-1:0]        net_ofs;
  logic [31:0]              scaled;
  logic [IDX_W-1:0]         idx_r;
  logic [LEVEL_W-1:0]       level_r;
  logic [2:0]               v_r;
  logic [LEVEL_W-1:0]       lut [SIGMOID_ENTRIES];

  for (genvar g = 0; g < SIGMOID_ENTRIES; g++) begin : g_lut
    localparam longint CENTRE = -32768 + ((2 * longint'(g) + 1) * 32768) / SIGMOID_ENTRIES;
    localparam logic [LEVEL_W-1:0] ENTRY = sigmoid_entry(CENTRE);
    assign lut[g] = ENTRY;
  end

  // floor of acc / 4096 is the arithmetic shift
  assign net_full = acc[ACC_W-1:FRAC_W];
  assign pos_ovf  = !net_full[NF_W-1] && (|net_full[NF_W-2:DATA_W-1]);
  assign neg_ovf  = net_full[NF_W-1] && !(&net_full[NF_W-2:DATA_W-1]);

  always_comb begin
    priority if (pos_ovf) begin
      net_sat = 16'sh7fff;
    end else if (neg_ovf) begin
      net_sat = 16'sh8000;
    end else begin
      net_sat = net_full[DATA_W-1:0];
    end
  end

  // net + 32768 as unsigned, scaled to the table size
  assign net_ofs = {~net_r[DATA_W-1], net_r[DATA_W-2:0]};
  assign scaled  = 32'(net_ofs) * 32'(SIGMOID_ENTRIES);

  always_ff @(posedge clk) begin
    net_r   <= net_sat;
    idx_r   <= scaled[DATA_W +: IDX_W];
    level_r <= lut[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], start};
    end
  end

  assign done  = v_r[2];
  assign level = level_r;

endmodule

// ===== hdl/perceptron_sigmoid_delta_rule_core.sv =====
// Single-layer perceptron, Q4.12 weights and inputs, sigmoid output in Q1.15.
// Command channel: an item (in_op, in_index, in_value, in_expected) transfers
// on a rising edge with start high and busy low. busy stays high until the
// result has been shown. Each item gives one result: out_output_level and
// out_fired, on the ports for one cycle with out_valid high; the receiver
// cannot stall it.
// From transfer to result strobe (N = NUM_INPUTS): an input or weight write
// goes straight to the strobe; train makes N+1 weight reads, passes the last
// product through the multiplier pipeline, then strobes; execute does the same
// plus the table lookup before the strobe. A new item can transfer in the cycle
// after the strobe. The walk is set by the one read port per store and the
// single shared multiplier, one weight per cycle.
// Reset: learn_rate 0.5, bias input 1.0, all weights, inputs and the output
// level zero, at once; no clearing pass. Registers are to be written over the APB
// port only while the core is idle; the core itself does not enforce this.
`include "perceptron_sigmoid_delta_rule_core_macros.svh"
module perceptron_sigmoid_delta_rule_core import psdr_pkg::*; #(
  parameter int NUM_INPUTS      = NUM_INPUTS_DEF,
  parameter int SIGMOID_ENTRIES = SIGMOID_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          in_op,
  input  logic [INDEX_W-1:0]       in_index,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [DATA_W-1:0]        in_expected,
  output logic                     out_valid,
  output logic [LEVEL_W-1:0]       out_output_level,
  output logic                     out_fired,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_AW-1:0]        paddr,
  input  logic [CFG_DW-1:0]        pwdata,
  output logic [CFG_DW-1:0]        prdata,
  output logic                     pready
);

  localparam int IA_W  = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int WA_W  = $clog2(NUM_INPUTS + 1);
  localparam int ACC_W = 32 + $clog2(NUM_INPUTS + 1);
  localparam int CMP_W = (WA_W > INDEX_W) ? WA_W : INDEX_W;

  cfg_t                     cfg;
  op_t                      op;
  logic                     accept;
  logic [CMP_W-1:0]         idx_ext;
  logic                     in_ok;
  logic                     w_ok;

  state_t                   state_r;
  state_t                   state_nxt;
  logic [WA_W-1:0]          k_r;
  logic [WA_W-1:0]          k_nxt;
  logic [WA_W-1:0]          km1;
  logic                     dcnt_r;
  logic                     dcnt_nxt;
  logic                     train_r;
  logic                     train_nxt;
  logic [LEVEL_W-1:0]       level_r;
  logic [LEVEL_W-1:0]       level_nxt;

  logic                     x_we;
  logic [IA_W-1:0]          x_raddr;
  logic signed [DATA_W-1:0] x_rd;
  logic                     w_we;
  logic [WA_W-1:0]          w_waddr;
  logic signed [DATA_W-1:0] w_wdata;
  logic signed [DATA_W-1:0] w_rd;

  mac_ctrl_t                mac_ctrl;
  logic                     re_load;
  logic signed [DATA_W-1:0] x0;
  logic signed [ACC_W-1:0]  acc;
  wb_t                      wb;
  logic [WA_W-1:0]          wb_addr;

  logic                     sig_done;
  logic [LEVEL_W-1:0]       sig_level;

  psdr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign accept  = start && !busy;
  assign op      = op_t'(in_op);
  assign idx_ext = CMP_W'(in_index);
  assign in_ok   = idx_ext < CMP_W'(NUM_INPUTS);
  assign w_ok    = idx_ext <= CMP_W'(NUM_INPUTS);

  // input store: written by commands, read one element per walk step
  assign x_we    = accept && (op == OP_WR_INPUT) && in_ok;
  assign km1     = k_r - WA_W'(1);
  assign x_raddr = (k_r == '0) ? '0 : km1[IA_W-1:0];

  psdr_mem #(
    .DEPTH (NUM_INPUTS),
    .WIDTH (DATA_W)
  ) u_input_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (x_we),
    .waddr (idx_ext[IA_W-1:0]),
    .wdata (in_value),
    .raddr (x_raddr),
    .rdata (x_rd)
  );

  // weight store: command writes only while idle, write-back only during a walk
  assign w_we    = (accept && (op == OP_WR_WEIGHT) && w_ok) || wb.en;
  assign w_waddr = wb.en ? wb_addr : idx_ext[WA_W-1:0];
  assign w_wdata = wb.en ? wb.data : in_value;

  psdr_mem #(
    .DEPTH (NUM_INPUTS + 1),
    .WIDTH (DATA_W)
  ) u_weight_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (k_r),
    .rdata (w_rd)
  );

  assign mac_ctrl.vld   = (state_r == ST_MAC);
  assign mac_ctrl.first = (k_r == '0);
  assign mac_ctrl.train = train_r;
  assign re_load        = accept && (op == OP_TRAIN);
  assign x0             = train_r ? cfg.bias_value : X_ONE;

  psdr_mac #(
    .NUM_INPUTS (NUM_INPUTS)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (mac_ctrl),
    .k          (k_r),
    .re_load    (re_load),
    .learn_rate (cfg.learn_rate),
    .expected   (in_expected),
    .level      (level_r),
    .x0         (x0),
    .w_rd       (w_rd),
    .x_rd       (x_rd),
    .acc        (acc),
    .wb         (wb),
    .wb_addr    (wb_addr)
  );

  psdr_sigmoid #(
    .ACC_W           (ACC_W),
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
  ) u_sigmoid (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_LOOKUP),
    .acc   (acc),
    .done  (sig_done),
    .level (sig_level)
  );

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    dcnt_nxt  = dcnt_r;
    train_nxt = train_r;
    level_nxt = level_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          train_nxt = (op == OP_TRAIN);
          if ((op == OP_EXECUTE) || (op == OP_TRAIN)) begin
            state_nxt = ST_MAC;
            k_nxt     = '0;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_MAC: begin
        if (k_r == WA_W'(NUM_INPUTS)) begin
          state_nxt = ST_DRAIN;
          dcnt_nxt  = 1'b0;
        end else begin
          k_nxt = k_r + WA_W'(1);
        end
      end
      ST_DRAIN: begin
        // hold, counted by dcnt_r, until the last product is accumulated or written back
        if (dcnt_r) begin
          state_nxt = train_r ? ST_DONE : ST_LOOKUP;
        end else begin
          dcnt_nxt = 1'b1;
        end
      end
      ST_LOOKUP: begin
        if (sig_done) begin
          level_nxt = sig_level;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      dcnt_r  <= 1'b0;
      train_r <= 1'b0;
      level_r <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      dcnt_r  <= dcnt_nxt;
      train_r <= train_nxt;
      level_r <= level_nxt;
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = (state_r == ST_DONE);
  assign out_output_level = level_r;
  assign out_fired        = |level_r[LEVEL_W-1:LEVEL_W-2];

  `PSDR_ASSERT_NXT(a_accept_sets_busy, start && !busy, busy, "transfer did not raise busy")
  `PSDR_ASSERT_NXT(a_result_frees, out_valid, !busy, "core still busy after result")
  `PSDR_ASSERT_IMP(a_result_has_item, out_valid, $past(start) || $past(busy),
                   "result strobe without a transferred item")
  `PSDR_ASSERT_IMP(a_walk_bound, state_r == ST_MAC, k_r <= WA_W'(NUM_INPUTS),
                   "weight walk index past last weight")
  `PSDR_ASSERT_IMP(a_wb_in_walk, wb.en, state_r == ST_MAC || state_r == ST_DRAIN,
                   "weight write-back outside a train walk")

endmodule
